// ----- src/hspr_pkg.sv -----
package hspr_pkg;

    localparam int DATA_BITS   = 40;
    localparam int TDATA_OUT_W = 40;

    localparam logic [15:0] BIT_THRESHOLD_RST = 16'd100;
    localparam logic [15:0] POWERUP_MS_RST    = 16'd1000;
    localparam logic [7:0]  REQUEST_MS_RST    = 8'd2;
    localparam logic [7:0]  TIMEOUT_MS_RST    = 8'd6;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_POWERUP = 3'd0,
        PH_IDLE    = 3'd1,
        PH_REQUEST = 3'd2,
        PH_REQWAIT = 3'd3,
        PH_CAPTURE = 3'd4,
        PH_DECODE  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_EDGE  = 2'd2,
        MODE_TAKE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_BIT_THRESHOLD = 2'd0,
        REG_POWERUP_MS    = 2'd1,
        REG_REQUEST_MS    = 2'd2,
        REG_TIMEOUT_MS    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [15:0] bit_threshold;
        logic [15:0] powerup_ms;
        logic [7:0]  request_ms;
        logic [7:0]  timeout_ms;
    } cfg_t;

    // Declared from the highest bit down, so a plain cast gives the stream
    // layout with the phase in the lowest bits.
    typedef struct packed {
        logic        timed_out;
        logic        reading_done;
        logic [15:0] temperature_word;
        logic [15:0] humidity_word;
        logic        reading_valid;
        logic        capture_armed;
        logic        drive_line_low;
        logic [2:0]  phase;
    } result_t;

endpackage

// ----- src/humidity_sensor_pulse_reader.sv -----
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser = event kind, s_tdata = edge timestamp
// m_        out  m_tvalid/m_tready  m_tdata = phase, line and capture flags, reading
// cfg_      in   cfg_wr_en          cfg_addr selects the register, cfg_wr_data the value
//
// Every accepted request yields exactly one result: it is held in the input
// register, then passes through the controller step into the output register.
// A new request is accepted every cycle while m_ is not stalled.
// The controller state advances only when the input register hands its
// request to the output register, so any stall on m_ simply holds both stages.
// Reset is synchronous and active low; it returns the controller to powerup
// and the configuration registers to their default values.
module humidity_sensor_pulse_reader #(
    parameter int LEADING_EDGES = 3
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] edge_time
    input  logic [1:0]  s_tuser,    // [1:0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] phase, [3] drive_line_low, [4] capture_armed, [5] reading_valid,
    // [21:6] humidity_word, [37:22] temperature_word, [38] reading_done,
    // [39] timed_out
    output logic [39:0] m_tdata,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data
);
    import hspr_pkg::*;

    cfg_t        cfg;
    result_t     step_result;

    logic        in_valid_reg;
    logic [15:0] in_time_reg;
    logic [1:0]  in_mode_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic        advance;

    // The input register moves forward whenever the output register is
    // empty or being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hspr_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    hspr_ctrl #(
        .LEADING_EDGES (LEADING_EDGES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .mode      (in_mode_reg),
        .edge_time (in_time_reg),
        .cfg       (cfg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_time_reg <= s_tdata;
            in_mode_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(out_data_reg);

    // A finished decode always lands in idle.
    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.reading_done |-> out_data_reg.phase == PH_IDLE)
        else $error("decode did not return to idle");

    // A timeout always lands in powerup and never coincides with a decode.
    a_tout_to_powerup: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.timed_out |->
            out_data_reg.phase == PH_POWERUP && !out_data_reg.reading_done)
        else $error("timeout result inconsistent");

    // The line is never driven low while edges are being captured.
    a_drive_vs_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg.drive_line_low && out_data_reg.capture_armed))
        else $error("line driven low during capture");

    // A request taken into the input register shows up as a result next cycle
    // unless the output side is stalled.
    a_pipe_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("request lost between stages");

endmodule

// ----- src/hspr_cfg.sv -----
module hspr_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wr_data,
    output hspr_pkg::cfg_t     cfg
);
    import hspr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_threshold <= BIT_THRESHOLD_RST;
            cfg_reg.powerup_ms    <= POWERUP_MS_RST;
            cfg_reg.request_ms    <= REQUEST_MS_RST;
            cfg_reg.timeout_ms    <= TIMEOUT_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_addr))
                REG_BIT_THRESHOLD: cfg_reg.bit_threshold <= cfg_wr_data;
                REG_POWERUP_MS:    cfg_reg.powerup_ms    <= cfg_wr_data;
                REG_REQUEST_MS:    cfg_reg.request_ms    <= cfg_wr_data[7:0];
                REG_TIMEOUT_MS:    cfg_reg.timeout_ms    <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/hspr_ctrl.sv -----
module hspr_ctrl #(
    parameter int LEADING_EDGES = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic [1:0]         mode,
    input  logic [15:0]        edge_time,
    input  hspr_pkg::cfg_t     cfg,
    output hspr_pkg::result_t  result
);
    import hspr_pkg::*;

    localparam int TOTAL_EDGES = LEADING_EDGES + DATA_BITS;
    localparam int CNT_W       = $clog2(TOTAL_EDGES + 1);

    phase_t                 phase_reg, phase_next;
    logic [15:0]            elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [15:0]            prev_edge_reg, prev_edge_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [15:0]            hum_reg, hum_next;
    logic [15:0]            temp_reg, temp_next;
    logic                   valid_reg, valid_next;

    logic [15:0]            elapsed_inc;
    logic [15:0]            gap;
    logic [7:0]             checksum;
    logic                   done;
    logic                   tout;
    logic                   shown_valid;

    assign elapsed_inc = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign gap         = edge_time - prev_edge_reg;
    assign checksum    = shift_reg[39:32] + shift_reg[31:24] + shift_reg[23:16]
                       + shift_reg[15:8];

    always_comb begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        count_next     = count_reg;
        prev_edge_next = prev_edge_reg;
        shift_next     = shift_reg;
        hum_next       = hum_reg;
        temp_next      = temp_reg;
        valid_next     = valid_reg;
        done           = 1'b0;
        tout           = 1'b0;

        unique case (mode_t'(mode))
            MODE_TICK: begin
                elapsed_next = elapsed_inc;
                unique case (phase_reg)
                    PH_POWERUP: begin
                        if (elapsed_inc > cfg.powerup_ms) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_REQUEST: begin
                        elapsed_next = '0;
                        phase_next   = PH_REQWAIT;
                    end
                    PH_REQWAIT: begin
                        if (elapsed_inc >= {8'd0, cfg.request_ms}) begin
                            elapsed_next = '0;
                            count_next   = '0;
                            shift_next   = '0;
                            phase_next   = PH_CAPTURE;
                        end
                    end
                    PH_CAPTURE: begin
                        if (count_reg == CNT_W'(TOTAL_EDGES)) begin
                            phase_next = PH_DECODE;
                        end
                        // A timeout overrides a completed capture.
                        if (elapsed_inc > {8'd0, cfg.timeout_ms}) begin
                            phase_next   = PH_POWERUP;
                            elapsed_next = '0;
                            tout         = 1'b1;
                        end
                    end
                    PH_DECODE: begin
                        if (checksum == shift_reg[7:0]) begin
                            hum_next   = shift_reg[39:24];
                            temp_next  = shift_reg[23:8];
                            valid_next = 1'b1;
                        end else begin
                            valid_next = 1'b0;
                        end
                        elapsed_next = '0;
                        phase_next   = PH_IDLE;
                        done         = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_START: begin
                if (phase_reg == PH_IDLE) begin
                    phase_next = PH_REQUEST;
                end
            end
            MODE_EDGE: begin
                if (phase_reg == PH_CAPTURE && count_reg < CNT_W'(TOTAL_EDGES)) begin
                    if (count_reg >= CNT_W'(LEADING_EDGES)) begin
                        shift_next = {shift_reg[DATA_BITS-2:0], (gap > cfg.bit_threshold)};
                    end
                    prev_edge_next = edge_time;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            MODE_TAKE: begin
                valid_next = 1'b0;
            end
            default: ;
        endcase
    end

    // A take request reports the flag as it was before clearing it.
    assign shown_valid = (mode_t'(mode) == MODE_TAKE) ? valid_reg : valid_next;

    always_comb begin
        result.phase            = phase_next;
        result.drive_line_low   = (phase_next == PH_REQWAIT);
        result.capture_armed    = (phase_next == PH_CAPTURE);
        result.reading_valid    = shown_valid;
        result.humidity_word    = hum_next;
        result.temperature_word = temp_next;
        result.reading_done     = done;
        result.timed_out        = tout;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_POWERUP;
            elapsed_reg   <= '0;
            count_reg     <= '0;
            prev_edge_reg <= '0;
            shift_reg     <= '0;
            hum_reg       <= '0;
            temp_reg      <= '0;
            valid_reg     <= 1'b0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            count_reg     <= count_next;
            prev_edge_reg <= prev_edge_next;
            shift_reg     <= shift_next;
            hum_reg       <= hum_next;
            temp_reg      <= temp_next;
            valid_reg     <= valid_next;
        end
    end

endmodule

// ----- bench/tb_humidity_sensor_pulse_reader.sv -----
`timescale 1ns / 1ps

// Testbench for the single-wire humidity sensor reader.
//
// Every request is one event for the controller: a millisecond tick, a start
// request, a captured edge timestamp or a take-reading request. The bench
// keeps its own copy of the controller (phase, elapsed time, edge counter,
// shift register, stored words and valid flag) and steps it once for every
// request that the block accepts. The predicted result goes into a queue,
// and a monitor compares every result the block hands out, field by field,
// with the oldest prediction.
//
// Inputs are driven on the falling clock edge and the handshakes are sampled
// on the rising edge. Predictions are pushed on the falling edge after the
// request was taken, so the monitor never races with the push.
//
// The run starts with short directed checks (reset state, the request cycle
// with a zero request time and a capture timeout) and then sends complete
// sensor frames with random bytes. Most frames are well formed; the rest
// carry a bad checksum, extra edges, an early timeout or random events mixed
// in. Frames run under several register settings and under four idling
// patterns on both sides of the block.
module tb_humidity_sensor_pulse_reader;
    import hspr_pkg::*;

    localparam int LEAD_EDGES     = 3;
    localparam int FRAME_EDGES    = LEAD_EDGES + DATA_BITS;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 6;
    localparam int FRAME_BUDGET   = 120;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;               // [15:0] edge_time
    logic [1:0]  s_tuser;               // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;               // result_t layout, phase in the lowest bits
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wr_data;

    humidity_sensor_pulse_reader #(
        .LEADING_EDGES(LEAD_EDGES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // Bench copy of the controller and of its registers.
    cfg_t        shadow_cfg;
    phase_t      rd_phase;
    logic [15:0] rd_elapsed;
    logic [5:0]  rd_edge_cnt;
    logic [15:0] rd_last_edge;
    logic [39:0] rd_bits;
    logic [15:0] rd_humidity;
    logic [15:0] rd_temperature;
    logic        rd_valid;

    result_t expected_readings[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatch_count = 0;
    int requests_sent = 0;
    int frame_requests = 0;
    int frames_sent = 0;
    int decodes_seen = 0;
    int checksum_passes = 0;
    int timeouts_seen = 0;

    task automatic reset_reader_model();
        shadow_cfg.bit_threshold = BIT_THRESHOLD_RST;
        shadow_cfg.powerup_ms    = POWERUP_MS_RST;
        shadow_cfg.request_ms    = REQUEST_MS_RST;
        shadow_cfg.timeout_ms    = TIMEOUT_MS_RST;
        rd_phase       = PH_POWERUP;
        rd_elapsed     = '0;
        rd_edge_cnt    = '0;
        rd_last_edge   = '0;
        rd_bits        = '0;
        rd_humidity    = '0;
        rd_temperature = '0;
        rd_valid       = 1'b0;
    endtask

    // Steps the bench controller by one event and returns what the block
    // should report for it.
    function automatic result_t advance_reader(input mode_t kind, input logic [15:0] stamp);
        result_t     r;
        logic        done;
        logic        tout;
        logic        shown;
        logic [15:0] gap;
        logic [7:0]  sum;
        done = 1'b0;
        tout = 1'b0;
        case (kind)
            MODE_TICK: begin
                if (rd_elapsed != ELAPSED_MAX) rd_elapsed = rd_elapsed + 16'd1;
                case (rd_phase)
                    PH_POWERUP: begin
                        if (rd_elapsed > shadow_cfg.powerup_ms) rd_phase = PH_IDLE;
                    end
                    PH_REQUEST: begin
                        rd_elapsed = '0;
                        rd_phase   = PH_REQWAIT;
                    end
                    PH_REQWAIT: begin
                        if (rd_elapsed >= {8'd0, shadow_cfg.request_ms}) begin
                            rd_elapsed  = '0;
                            rd_edge_cnt = '0;
                            rd_bits     = '0;
                            rd_phase    = PH_CAPTURE;
                        end
                    end
                    PH_CAPTURE: begin
                        if (rd_edge_cnt == 6'(FRAME_EDGES)) rd_phase = PH_DECODE;
                        // A timeout on the same tick beats a complete frame.
                        if (rd_elapsed > {8'd0, shadow_cfg.timeout_ms}) begin
                            rd_phase   = PH_POWERUP;
                            rd_elapsed = '0;
                            tout       = 1'b1;
                        end
                    end
                    PH_DECODE: begin
                        sum = rd_bits[39:32] + rd_bits[31:24] + rd_bits[23:16] + rd_bits[15:8];
                        if (rd_bits[7:0] == sum) begin
                            rd_humidity    = rd_bits[39:24];
                            rd_temperature = rd_bits[23:8];
                            rd_valid       = 1'b1;
                        end else begin
                            // The stored words keep the last good reading.
                            rd_valid = 1'b0;
                        end
                        rd_elapsed = '0;
                        rd_phase   = PH_IDLE;
                        done       = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_START: begin
                if (rd_phase == PH_IDLE) rd_phase = PH_REQUEST;
            end
            MODE_EDGE: begin
                if (rd_phase == PH_CAPTURE && rd_edge_cnt < 6'(FRAME_EDGES)) begin
                    if (rd_edge_cnt >= 6'(LEAD_EDGES)) begin
                        gap     = stamp - rd_last_edge;
                        rd_bits = {rd_bits[38:0], gap > shadow_cfg.bit_threshold};
                    end
                    rd_last_edge = stamp;
                    rd_edge_cnt  = rd_edge_cnt + 6'd1;
                end
            end
            default: ;
        endcase

        // A take-reading request reports the flag as it was, then clears it.
        shown = rd_valid;
        if (kind == MODE_TAKE) rd_valid = 1'b0;

        if (done) begin
            decodes_seen++;
            if (rd_valid) checksum_passes++;
        end
        if (tout) timeouts_seen++;

        r.phase            = rd_phase;
        r.drive_line_low   = (rd_phase == PH_REQWAIT);
        r.capture_armed    = (rd_phase == PH_CAPTURE);
        r.reading_valid    = shown;
        r.humidity_word    = rd_humidity;
        r.temperature_word = rd_temperature;
        r.reading_done     = done;
        r.timed_out        = tout;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_reading(input logic [39:0] raw);
        result_t got;
        result_t want;
        got = result_t'(raw);
        if (expected_readings.size() == 0) begin
            report_mismatch("result with no request pending", raw, '0);
            return;
        end
        want = expected_readings.pop_front();
        if (got.phase !== want.phase)
            report_mismatch("phase", 40'(got.phase), 40'(want.phase));
        if (got.drive_line_low !== want.drive_line_low)
            report_mismatch("drive_line_low", 40'(got.drive_line_low),
                            40'(want.drive_line_low));
        if (got.capture_armed !== want.capture_armed)
            report_mismatch("capture_armed", 40'(got.capture_armed),
                            40'(want.capture_armed));
        if (got.reading_valid !== want.reading_valid)
            report_mismatch("reading_valid", 40'(got.reading_valid),
                            40'(want.reading_valid));
        if (got.humidity_word !== want.humidity_word)
            report_mismatch("humidity_word", 40'(got.humidity_word),
                            40'(want.humidity_word));
        if (got.temperature_word !== want.temperature_word)
            report_mismatch("temperature_word", 40'(got.temperature_word),
                            40'(want.temperature_word));
        if (got.reading_done !== want.reading_done)
            report_mismatch("reading_done", 40'(got.reading_done),
                            40'(want.reading_done));
        if (got.timed_out !== want.timed_out)
            report_mismatch("timed_out", 40'(got.timed_out), 40'(want.timed_out));
    endtask

    // Result side: every accepted result is checked at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_reading(m_tdata);
    end

    // Receiver back-pressure, redrawn on every falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Sends one request. It is entered and left at a falling edge; the
    // prediction is made on the falling edge that follows the handshake.
    task automatic send_event(input mode_t kind, input logic [15:0] stamp);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = stamp;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        expected_readings.push_back(advance_reader(kind, stamp));
        requests_sent++;
    endtask

    // Lets every result come back, then a few more cycles for the pipeline.
    task automatic drain_pipeline();
        s_tvalid = 1'b0;
        while (expected_readings.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [15:0] value);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_BIT_THRESHOLD: shadow_cfg.bit_threshold = value;
            REG_POWERUP_MS:    shadow_cfg.powerup_ms    = value;
            REG_REQUEST_MS:    shadow_cfg.request_ms    = value[7:0];
            REG_TIMEOUT_MS:    shadow_cfg.timeout_ms    = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] threshold, input logic [15:0] powerup,
                                 input logic [7:0] req_ms, input logic [7:0] tmo_ms);
        drain_pipeline();
        write_register(REG_BIT_THRESHOLD, threshold);
        write_register(REG_POWERUP_MS, powerup);
        write_register(REG_REQUEST_MS, {8'd0, req_ms});
        write_register(REG_TIMEOUT_MS, {8'd0, tmo_ms});
    endtask

    // Edge spacing that decodes to the wanted bit under the current threshold
    // (a zero at threshold 16'hFFFF), with the values right at it drawn often.
    function automatic logic [15:0] gap_for_bit(input logic one);
        int thr;
        thr = shadow_cfg.bit_threshold;
        if (one && thr < 65535) begin
            if ($urandom_range(3) == 0) return 16'(thr + 1);
            return 16'($urandom_range(65535, thr + 1));
        end
        if ($urandom_range(3) == 0) return 16'(thr);
        return 16'($urandom_range(thr, 0));
    endfunction

    task automatic tick_until_idle();
        while (rd_phase != PH_IDLE) send_event(MODE_TICK, 16'($urandom));
    endtask

    // One sensor transaction from idle: start, line held low, capture of the
    // leading edges and forty data edges, decode. Some frames are broken on
    // purpose.
    task automatic run_frame();
        logic [39:0] payload;
        logic [7:0]  sum;
        logic [15:0] stamp;
        int          flavor;
        int          spare_ticks;
        int          cut_at;
        int          e;
        flavor = $urandom_range(99);
        tick_until_idle();
        if ($urandom_range(3) == 0) send_event(MODE_TAKE, 16'($urandom));
        send_event(MODE_START, 16'($urandom));
        while (rd_phase == PH_REQUEST || rd_phase == PH_REQWAIT)
            send_event(MODE_TICK, 16'($urandom));

        payload[39:8] = $urandom;
        sum = payload[39:32] + payload[31:24] + payload[23:16] + payload[15:8];
        if (flavor >= 65 && flavor < 75) payload[7:0] = sum ^ 8'($urandom_range(255, 1));
        else payload[7:0] = sum;

        // Ticks mixed into the capture must leave room for the tick that
        // finds the frame complete.
        if (shadow_cfg.timeout_ms > 0)
            spare_ticks = $urandom_range((shadow_cfg.timeout_ms > 3) ? 3 :
                                         shadow_cfg.timeout_ms - 1, 0);
        else
            spare_ticks = 0;
        cut_at = (flavor >= 83 && flavor < 91) ? $urandom_range(FRAME_EDGES - 1, 0) : FRAME_EDGES;

        stamp = 16'($urandom);
        for (e = 0; e < FRAME_EDGES; e++) begin
            if (e == cut_at) begin
                // The sensor stops answering: run into the capture timeout.
                while (rd_phase == PH_CAPTURE) send_event(MODE_TICK, 16'($urandom));
                break;
            end
            if (spare_ticks > 0 && $urandom_range(9) == 0) begin
                send_event(MODE_TICK, 16'($urandom));
                spare_ticks--;
            end
            if (flavor >= 91 && $urandom_range(5) == 0)
                send_event(mode_t'($urandom_range(3)), 16'($urandom));
            if (e < LEAD_EDGES) stamp = 16'($urandom);
            else stamp = stamp + gap_for_bit(payload[39 - (e - LEAD_EDGES)]);
            send_event(MODE_EDGE, stamp);
        end

        // Edges after a complete frame are dropped by the block.
        if (flavor >= 75 && flavor < 83)
            repeat ($urandom_range(3, 1)) send_event(MODE_EDGE, 16'($urandom));

        tick_until_idle();
        if ($urandom_range(1) == 0) send_event(MODE_TAKE, 16'($urandom));
        frames_sent++;
    endtask

    task automatic run_frames(input int budget);
        int first;
        first = requests_sent;
        do run_frame(); while (requests_sent - first < budget);
        frame_requests += requests_sent - first;
    endtask

    // Right after reset: start and edges are ignored in powerup, nothing is
    // valid yet, and the default powerup time is far away.
    task automatic test_reset_state();
        send_event(MODE_TAKE, 16'h0000);
        send_event(MODE_START, 16'hFFFF);
        send_event(MODE_EDGE, 16'hFFFF);
        send_event(MODE_EDGE, 16'h0000);
        send_event(MODE_TICK, 16'hFFFF);
        send_event(MODE_TICK, 16'h0000);
    endtask

    // The request cycle with zero powerup and zero request time, requests in the
    // wrong phase, and a capture that times out after part of the leading edges.
    task automatic test_request_and_timeout();
        drain_pipeline();
        write_register(REG_POWERUP_MS, 16'd0);
        write_register(REG_REQUEST_MS, 16'd0);
        send_event(MODE_TICK, 16'h5A5A);
        send_event(MODE_EDGE, 16'h1234);
        send_event(MODE_START, 16'h0000);
        send_event(MODE_START, 16'hA5A5);
        send_event(MODE_TAKE, 16'h0000);
        send_event(MODE_EDGE, 16'hFFFF);
        send_event(MODE_TICK, 16'h0000);
        send_event(MODE_START, 16'h0000);
        send_event(MODE_TICK, 16'hFFFF);
        send_event(MODE_START, 16'hFFFF);
        send_event(MODE_EDGE, 16'h0000);
        send_event(MODE_EDGE, 16'hFFFF);
        while (rd_phase == PH_CAPTURE) send_event(MODE_TICK, 16'h0000);
    endtask

    // Random frames under eight register settings, two per idling pattern.
    task automatic test_reading_frames();
        int pattern;
        int k;
        int setting;
        for (pattern = 0; pattern < 4; pattern++) begin
            case (pattern)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
                default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            endcase
            for (k = 0; k < 2; k++) begin
                setting = pattern * 2 + k;
                case (setting)
                    0: apply_setting(BIT_THRESHOLD_RST, 16'd3, REQUEST_MS_RST, TIMEOUT_MS_RST);
                    1: apply_setting(16'd0, 16'd0, 8'd0, 8'd255);
                    2: apply_setting(16'hFFFF, 16'd1, 8'd1, 8'd20);
                    // Longest request and timeout; one frame is plenty.
                    4: apply_setting(16'($urandom), 16'd2, 8'd255, 8'd255);
                    // Every capture times out, even a complete one.
                    5: apply_setting(16'($urandom), 16'd0, 8'd1, 8'd0);
                    default: apply_setting(16'($urandom), 16'($urandom_range(8)),
                                           8'($urandom_range(6)), 8'($urandom_range(60)));
                endcase
                run_frames((setting == 4) ? 1 : FRAME_BUDGET);
            end
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_TICK;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_BIT_THRESHOLD;
        cfg_wr_data = '0;
        reset_reader_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_request_and_timeout();
        test_reading_frames();
        drain_pipeline();

        $display("Sent %0d requests, %0d of them in %0d sensor frames after the directed part.",
                 requests_sent, frame_requests, frames_sent);
        $display("Saw %0d decodes (%0d with a good checksum) and %0d capture timeouts.",
                 decodes_seen, checksum_passes, timeouts_seen);
        if (mismatch_count == 0) begin
            $display("tb_humidity_sensor_pulse_reader: clean");
        end else begin
            $display("tb_humidity_sensor_pulse_reader: errors");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs only a small part of this.
    initial begin
        #50_000_000;
        $display("Run stopped by the watchdog with %0d results outstanding.",
                 expected_readings.size());
        $display("tb_humidity_sensor_pulse_reader: errors");
        $finish;
    end

endmodule
